// ===== sv/stg_pkg.sv =====
// ----------------------------------------------------------------------------
// stg_pkg: shared constants, types and sine table for the sine tone generator
// Holds the output-rate derived constants, the register index codes and the
// quarter-wave sine table, which is built at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none

package stg_pkg;

  localparam int OUTPUT_RATE_HZ = 48000;
  localparam int HALF_RATE      = OUTPUT_RATE_HZ / 2;
  // Exact because the rate is a whole number of kHz
  localparam int SAMPLES_PER_MS = OUTPUT_RATE_HZ / 1000;
  localparam int MAX_AMPLITUDE  = 16384;
  localparam int VOLUME_FULL    = 256;

  localparam int FREQ_W   = 15;
  localparam int DUR_W    = 16;
  localparam int VOL_W    = 9;
  localparam int PHASE_W  = 32;
  localparam int COUNT_W  = 22;
  localparam int AMP_W    = 15;
  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 16;

  // Phase step = f * 2^32 / 48000 = f * 89478 + floor(f * 182 / 375).
  // The fractional term is f * round_up(2^32 / 375) * 182 >> 32, exact for
  // every saturated frequency.
  localparam logic [31:0] STEP_WHOLE    = 32'd89478;
  localparam logic [31:0] STEP_FRAC_MUL = 32'd2084490954;

  // Sine table: quarter wave, Q1.30
  localparam int SINE_DEPTH = 256;
  localparam int SINE_IDX_W = $clog2(SINE_DEPTH);
  localparam int ROM_ADDR_W = SINE_IDX_W + 1;
  localparam int SINE_W     = 31;
  localparam int Q_SHIFT    = 30;
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
  localparam longint      ONE_Q30     = 64'sd1073741824;

  typedef enum logic [1:0] {
    CFG_FREQUENCY = 2'd0,
    CFG_DURATION  = 2'd1,
    CFG_VOLUME    = 2'd2
  } cfg_index_t;

  typedef logic [SINE_W-1:0] sine_rom_t [SINE_DEPTH+1];

  // Taylor series to x^15, each term truncated, clamped to [0, 1.0]
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    for (int k = 0; k <= SINE_DEPTH; k++) begin
      x    = (PI_HALF_Q30 * 64'(k)) / 64'(SINE_DEPTH);
      x2   = (x * x) >> Q_SHIFT;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2) >> Q_SHIFT) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) sum = 0;
      if (sum > ONE_Q30) sum = ONE_Q30;
      rom[k] = SINE_W'(sum);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

// ===== sv/sine_tone_generator_top.sv =====
// ----------------------------------------------------------------------------
// sine_tone_generator_top: direct digital synthesis sine tone generator
// Start transfers latch a tone from the configuration registers; tick
// transfers then produce one sample each until the tone is spent.
// ----------------------------------------------------------------------------
`default_nettype none

// The block takes one input transfer per clock unless a stalled output holds
// it. A start transfer (start_tone set) latches frequency, duration and volume
// and gives no output; each tick (start_tone clear) during a tone gives one
// 16-bit sample on the master side in the next cycle, with tlast on the final
// sample of the tone. Ticks while idle give nothing. The phase step, sample
// count and amplitude come from constant multiplies in the start cycle, and a
// sample is one sine table read and one multiply between the phase register
// and the output register. A stalled output holds the input side only while
// the output register is full. The phase carries over from tone to tone.
// Configuration writes are expected only while no tone is running.
module sine_tone_generator_top
  import stg_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // slave side
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [7:0]          s_tdata,   // [0] start_tone, rest zero
  // master side
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [SAMPLE_W-1:0]      m_tdata,   // [15:0] sample_value
  output logic                     m_tlast,   // last_sample
  // configuration
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_data
);

  logic [FREQ_W-1:0]   tone_frequency_hz;
  logic [DUR_W-1:0]    tone_duration_ms;
  logic [VOL_W-1:0]    tone_volume;

  logic [PHASE_W-1:0]  phase_accumulator;
  logic [PHASE_W-1:0]  phase_step;
  logic [COUNT_W-1:0]  samples_remaining;
  logic [AMP_W-1:0]    amplitude_level;

  logic                in_xfer;
  logic                start_xfer;
  logic                tick_xfer;

  logic [FREQ_W-1:0]   freq_sat;
  logic [VOL_W-1:0]    vol_sat;
  logic [31:0]         step_whole;
  logic [46:0]         step_frac;
  logic [PHASE_W-1:0]  phase_step_next;
  logic [COUNT_W-1:0]  samples_next;
  logic [AMP_W-1:0]    amplitude_next;

  logic [1:0]            quadrant;
  logic [SINE_IDX_W-1:0] sine_idx;
  logic [ROM_ADDR_W-1:0] rom_addr;
  logic [SINE_W-1:0]     sine_mag;
  logic [45:0]           product;
  logic [SAMPLE_W-1:0]   magnitude;
  logic [SAMPLE_W-1:0]   sample_next;

  assign s_tready   = !m_tvalid || m_tready;
  assign in_xfer    = s_tvalid && s_tready;
  assign start_xfer = in_xfer && s_tdata[0];
  assign tick_xfer  = in_xfer && !s_tdata[0] && (samples_remaining != '0);

  // Tone set-up
  always_comb begin
    freq_sat = (tone_frequency_hz > FREQ_W'(HALF_RATE)) ? FREQ_W'(HALF_RATE)
                                                        : tone_frequency_hz;
    vol_sat  = (tone_volume > VOL_W'(VOLUME_FULL)) ? VOL_W'(VOLUME_FULL) : tone_volume;
    step_whole      = 32'(freq_sat) * STEP_WHOLE;
    step_frac       = 47'(freq_sat) * 47'(STEP_FRAC_MUL);
    phase_step_next = step_whole + 32'(step_frac[46:32]);
    samples_next    = COUNT_W'(tone_duration_ms) * COUNT_W'(SAMPLES_PER_MS);
    amplitude_next  = AMP_W'((32'(vol_sat) * 32'(MAX_AMPLITUDE)) >> 8);
  end

  // Sample from the quarter-wave table
  always_comb begin
    quadrant    = phase_accumulator[PHASE_W-1 -: 2];
    sine_idx    = phase_accumulator[PHASE_W-3 -: SINE_IDX_W];
    rom_addr    = quadrant[0] ? ROM_ADDR_W'(SINE_DEPTH) - {1'b0, sine_idx}
                              : {1'b0, sine_idx};
    sine_mag    = SINE_ROM[rom_addr];
    product     = 46'(sine_mag) * 46'(amplitude_level);
    magnitude   = product[Q_SHIFT +: SAMPLE_W];
    sample_next = quadrant[1] ? (~magnitude + SAMPLE_W'(1)) : magnitude;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tone_frequency_hz <= FREQ_W'(1000);
      tone_duration_ms  <= DUR_W'(100);
      tone_volume       <= VOL_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FREQUENCY: tone_frequency_hz <= cfg_data[FREQ_W-1:0];
        CFG_DURATION:  tone_duration_ms  <= cfg_data[DUR_W-1:0];
        CFG_VOLUME:    tone_volume       <= cfg_data[VOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_accumulator <= '0;
      phase_step        <= '0;
      samples_remaining <= '0;
      amplitude_level   <= '0;
    end else if (start_xfer) begin
      // abandon any running tone, keep the phase
      phase_step        <= phase_step_next;
      samples_remaining <= samples_next;
      amplitude_level   <= amplitude_next;
    end else if (tick_xfer) begin
      phase_accumulator <= phase_accumulator + phase_step;
      samples_remaining <= samples_remaining - COUNT_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (tick_xfer) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_xfer) begin
      m_tdata <= sample_next;
      m_tlast <= (samples_remaining == COUNT_W'(1));
    end
  end

endmodule

`default_nettype wire
